// File: design/dspd_pkg.sv
package dspd_pkg;

   // Default sensor sample width
   localparam int SAMPLE_BITS_DEF = 12;

   // Register widths
   localparam int GAIN_W   = 10;
   localparam int DTIME_W  = 16;
   localparam int PERIOD_W = 16;
   localparam int LIMIT_W  = 12;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 2;

   // Register reset values
   localparam logic [GAIN_W-1:0]   PROP_GAIN_RST     = 10'd5;
   localparam logic [DTIME_W-1:0]  DERIV_TIME_RST    = 16'd2000;
   localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 16'd20;
   localparam logic [LIMIT_W-1:0]  PWM_LIMIT_RST     = 12'd100;

   // Error and drive formats
   localparam int ERR_W    = 16;
   localparam int FRAC_W   = 14;
   localparam int ACC_W    = LIMIT_W + FRAC_W;
   localparam int Q8_SHIFT = 6;
   localparam int DRIVE_W  = ACC_W - Q8_SHIFT;
   localparam logic signed [ERR_W-1:0] ERR_ONE = 16'sd16384;

   // Difference terms and the shared multiplier
   localparam int D1_W     = ERR_W + 1;
   localparam int D2_W     = ERR_W + 2;
   localparam int D1MAG_W  = ERR_W;
   localparam int MAG_W    = ERR_W + 1;
   localparam int MULA_W   = GAIN_W + DTIME_W;
   localparam int MUL_W    = MULA_W + MAG_W;
   localparam int P_W      = GAIN_W + D1MAG_W + 1;
   localparam int SUM_W    = MUL_W + 2;

   // Result bus width: drive then error, padded to bytes
   localparam int RSP_TDATA_W = ((DRIVE_W + ERR_W + 7) / 8) * 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PROP_GAIN     = 2'd0,
      REG_DERIV_TIME    = 2'd1,
      REG_SAMPLE_PERIOD = 2'd2,
      REG_PWM_LIMIT     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]   prop_gain;
      logic [DTIME_W-1:0]  deriv_time;
      logic [PERIOD_W-1:0] sample_period;
      logic [LIMIT_W-1:0]  pwm_limit;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR_DIV,
      ST_ERR_WAIT,
      ST_DIFF,
      ST_MUL_P,
      ST_MUL_KT,
      ST_MUL_D2,
      ST_D_DIV,
      ST_D_WAIT,
      ST_ADD_P,
      ST_ADD_D,
      ST_CLAMP,
      ST_DONE
   } state_type;

endpackage

// File: design/dspd_div.sv
module dspd_div
   import dspd_pkg::*;
#(
   parameter int NUM_W = MUL_W,
   parameter int DEN_W = PERIOD_W + 1,
   parameter int CNT_W = $clog2(MUL_W + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,  // left aligned
   input  logic [DEN_W-1:0] divisor,   // nonzero
   input  logic [CNT_W-1:0] steps,
   output logic [NUM_W-1:0] quotient,
   output div_stat_type     stat
);

   logic [NUM_W-1:0] shift_ff, shift_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   trial_sub;
   logic             trial_ge;

   // One restoring shift-subtract step per cycle
   always_comb begin
      trial     = {rem_ff, shift_ff[NUM_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      trial_ge  = (trial >= {1'b0, den_ff});
      shift_in  = shift_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         den_in   = divisor;
         cnt_in   = steps;
      end else if (cnt_ff != '0) begin
         shift_in = {shift_ff[NUM_W-2:0], trial_ge};
         rem_in   = trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in   = cnt_ff - 1'b1;
         done_in  = (cnt_ff == CNT_W'(1));
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
   end

   assign quotient  = shift_ff;
   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;

endmodule

// File: design/dspd_ctrl.sv
module dspd_ctrl
   import dspd_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [SAMPLE_BITS-1:0]  left_sample,
   input  logic [SAMPLE_BITS-1:0]  right_sample,
   output logic                    res_valid,
   input  logic                    res_ready,
   output logic [DRIVE_W-1:0]      res_drive,
   output logic signed [ERR_W-1:0] res_error
);

   localparam int ERR_NUM_W = SAMPLE_BITS + FRAC_W;
   localparam int NUM_W = (ERR_NUM_W > MUL_W) ? ERR_NUM_W : MUL_W;
   localparam int DEN_W = (SAMPLE_BITS + 1 > PERIOD_W) ? SAMPLE_BITS + 1 : PERIOD_W;
   localparam int CNT_W = $clog2(NUM_W + 1);

   // Multiplier operand selects
   localparam logic [1:0] MSEL_KP_D1 = 2'd0;
   localparam logic [1:0] MSEL_KP_TD = 2'd1;
   localparam logic [1:0] MSEL_KT_D2 = 2'd2;

   state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0]  left_ff, left_in;
   logic [SAMPLE_BITS-1:0]  right_ff, right_in;
   logic signed [ERR_W-1:0] e_ff, e_in;
   logic signed [ERR_W-1:0] e1_ff, e1_in;
   logic signed [ERR_W-1:0] e2_ff, e2_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic                    d1_neg_ff, d1_neg_in;
   logic                    d2_neg_ff, d2_neg_in;
   logic [D1MAG_W-1:0]      d1_mag_ff, d1_mag_in;
   logic [MAG_W-1:0]        d2_mag_ff, d2_mag_in;
   logic [MUL_W-1:0]        mul_ff, mul_in;
   logic signed [P_W-1:0]   pterm_ff, pterm_in;
   logic signed [SUM_W-1:0] dterm_ff, dterm_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;

   // Control outputs
   logic               div_start;
   logic               div_err_sel;
   logic [1:0]         mul_sel;
   logic [MULA_W-1:0]  mul_a;
   logic [MAG_W-1:0]   mul_b;
   logic [MUL_W-1:0]   mul_prod;

   // Divider connections
   logic [NUM_W-1:0]   div_dividend;
   logic [DEN_W-1:0]   div_divisor;
   logic [CNT_W-1:0]   div_steps;
   logic [NUM_W-1:0]   div_quo;
   div_stat_type       div_stat;

   // Error path
   logic [SAMPLE_BITS:0]    lr_sum;
   logic                    left_ge;
   logic [SAMPLE_BITS-1:0]  lr_abs;
   logic [ERR_NUM_W-1:0]    err_num;
   logic [ERR_W-1:0]        err_mag;
   logic signed [ERR_W-1:0] err_new;

   // Difference terms
   logic signed [D1_W-1:0]  d1;
   logic signed [D2_W-1:0]  d2;
   logic signed [D1_W-1:0]  d1_abs;
   logic signed [D2_W-1:0]  d2_abs;

   logic [PERIOD_W-1:0]     period_eff;
   logic [ACC_W-1:0]        acc_top;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_ERR_DIV;
         ST_ERR_DIV:  state_in = (lr_sum == '0) ? ST_DIFF : ST_ERR_WAIT;
         ST_ERR_WAIT: if (div_stat.done) state_in = ST_DIFF;
         ST_DIFF:     state_in = ST_MUL_P;
         ST_MUL_P:    state_in = ST_MUL_KT;
         ST_MUL_KT:   state_in = ST_MUL_D2;
         ST_MUL_D2:   state_in = ST_D_DIV;
         ST_D_DIV:    state_in = ST_D_WAIT;
         ST_D_WAIT:   if (div_stat.done) state_in = ST_ADD_P;
         ST_ADD_P:    state_in = ST_ADD_D;
         ST_ADD_D:    state_in = ST_CLAMP;
         ST_CLAMP:    state_in = ST_DONE;
         ST_DONE:     if (res_ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      div_start   = 1'b0;
      div_err_sel = 1'b0;
      mul_sel     = MSEL_KP_D1;
      case (state_ff)
         ST_IDLE:    req_ready = 1'b1;
         ST_ERR_DIV: begin
            div_start   = (lr_sum != '0);
            div_err_sel = 1'b1;
         end
         ST_MUL_P:   mul_sel = MSEL_KP_D1;
         ST_MUL_KT:  mul_sel = MSEL_KP_TD;
         ST_MUL_D2:  mul_sel = MSEL_KT_D2;
         ST_D_DIV:   div_start = 1'b1;
         ST_DONE:    res_valid = 1'b1;
         default:    mul_sel = MSEL_KP_D1;
      endcase
   end

   // Normalized difference operands
   always_comb begin
      lr_sum  = {1'b0, left_ff} + {1'b0, right_ff};
      left_ge = (left_ff >= right_ff);
      lr_abs  = left_ge ? (left_ff - right_ff) : (right_ff - left_ff);
      err_num = {lr_abs, {FRAC_W{1'b0}}};
      err_mag = (div_quo[ERR_NUM_W-1:0] > ERR_NUM_W'(ERR_ONE)) ?
                ERR_ONE : div_quo[ERR_W-1:0];
      err_new = left_ge ? $signed(err_mag) : -$signed(err_mag);
   end

   // Shared divider operand select
   always_comb begin
      period_eff = (cfg.sample_period == '0) ? PERIOD_W'(1) : cfg.sample_period;
      if (div_err_sel) begin
         div_dividend = NUM_W'(err_num) << (NUM_W - ERR_NUM_W);
         div_divisor  = DEN_W'(lr_sum);
         div_steps    = CNT_W'(ERR_NUM_W);
      end else begin
         div_dividend = NUM_W'(mul_ff) << (NUM_W - MUL_W);
         div_divisor  = DEN_W'(period_eff);
         div_steps    = CNT_W'(MUL_W);
      end
   end

   // Shared multiplier operand select
   always_comb begin
      case (mul_sel)
         MSEL_KP_D1: begin
            mul_a = MULA_W'(cfg.prop_gain);
            mul_b = MAG_W'(d1_mag_ff);
         end
         MSEL_KP_TD: begin
            mul_a = MULA_W'(cfg.prop_gain);
            mul_b = MAG_W'(cfg.deriv_time);
         end
         MSEL_KT_D2: begin
            mul_a = mul_ff[MULA_W-1:0];
            mul_b = d2_mag_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_prod = MUL_W'(mul_a) * MUL_W'(mul_b);
   end

   // Datapath next values
   always_comb begin
      d1      = D1_W'(e_ff) - D1_W'(e1_ff);
      d2      = D2_W'(e_ff) - (D2_W'(e1_ff) <<< 1) + D2_W'(e2_ff);
      d1_abs  = d1[D1_W-1] ? -d1 : d1;
      d2_abs  = d2[D2_W-1] ? -d2 : d2;
      acc_top = {cfg.pwm_limit, {FRAC_W{1'b0}}};

      left_in   = left_ff;
      right_in  = right_ff;
      e_in      = e_ff;
      e1_in     = e1_ff;
      e2_in     = e2_ff;
      acc_in    = acc_ff;
      d1_neg_in = d1_neg_ff;
      d2_neg_in = d2_neg_ff;
      d1_mag_in = d1_mag_ff;
      d2_mag_in = d2_mag_ff;
      mul_in    = mul_ff;
      pterm_in  = pterm_ff;
      dterm_in  = dterm_ff;
      sum_in    = sum_ff;

      case (state_ff)
         ST_IDLE: begin
            left_in  = left_sample;
            right_in = right_sample;
         end
         ST_ERR_DIV:  e_in = '0;
         ST_ERR_WAIT: if (div_stat.done) e_in = err_new;
         ST_DIFF: begin
            d1_neg_in = d1[D1_W-1];
            d2_neg_in = d2[D2_W-1];
            d1_mag_in = d1_abs[D1MAG_W-1:0];
            d2_mag_in = d2_abs[MAG_W-1:0];
         end
         ST_MUL_P:  mul_in = mul_prod;
         ST_MUL_KT: begin
            // take kp*|d1| out of the multiplier register, then load kp*td
            pterm_in = d1_neg_ff ? -$signed({1'b0, mul_ff[P_W-2:0]})
                                 :  $signed({1'b0, mul_ff[P_W-2:0]});
            mul_in   = mul_prod;
         end
         ST_MUL_D2: mul_in = mul_prod;
         ST_D_WAIT: if (div_stat.done) begin
            dterm_in = d2_neg_ff ? -$signed({2'b00, div_quo[MUL_W-1:0]})
                                 :  $signed({2'b00, div_quo[MUL_W-1:0]});
         end
         ST_ADD_P: sum_in = $signed({{(SUM_W-ACC_W){1'b0}}, acc_ff}) + SUM_W'(pterm_ff);
         ST_ADD_D: sum_in = sum_ff + dterm_ff;
         ST_CLAMP: begin
            if (sum_ff[SUM_W-1]) begin
               acc_in = '0;
            end else if (sum_ff > $signed({{(SUM_W-ACC_W){1'b0}}, acc_top})) begin
               acc_in = acc_top;
            end else begin
               acc_in = sum_ff[ACC_W-1:0];
            end
            e2_in = e1_ff;
            e1_in = e_ff;
         end
         default: e_in = e_ff;
      endcase
   end

   // Control and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         e1_ff    <= '0;
         e2_ff    <= '0;
         acc_ff   <= '0;
      end else begin
         state_ff <= state_in;
         e1_ff    <= e1_in;
         e2_ff    <= e2_in;
         acc_ff   <= acc_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      left_ff   <= left_in;
      right_ff  <= right_in;
      e_ff      <= e_in;
      d1_neg_ff <= d1_neg_in;
      d2_neg_ff <= d2_neg_in;
      d1_mag_ff <= d1_mag_in;
      d2_mag_ff <= d2_mag_in;
      mul_ff    <= mul_in;
      pterm_ff  <= pterm_in;
      dterm_ff  <= dterm_in;
      sum_ff    <= sum_in;
   end

   dspd_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   assign res_drive = acc_ff[ACC_W-1:Q8_SHIFT];
   assign res_error = e_ff;

   // Drive stays within the limit after each clamp
   a_acc_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLAMP) |=> (acc_ff <= {cfg.pwm_limit, {FRAC_W{1'b0}}}))
      else $error("drive accumulator above limit");

   // Divider finishes only while a quotient is awaited
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_ERR_WAIT || state_ff == ST_D_WAIT))
      else $error("divider done outside a wait state");

   // Divider is idle whenever a new division is started
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   // Error magnitude bounded by one
   a_err_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIFF) |-> (e_ff <= ERR_ONE && e_ff >= -ERR_ONE))
      else $error("error out of range");

   // History holds while the result waits
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !res_ready) |=>
         (state_ff == ST_DONE && $stable(e1_ff) && $stable(acc_ff)))
      else $error("controller state moved while result stalled");

endmodule

// File: design/differential_sensor_pd_controller.sv
// Differential sensor steering controller, incremental PD.
// req channel: one transaction carries a left and a right sensor sample. The block
// forms the normalized difference (l-r)/(l+r) in Q2.14 and runs one incremental
// PD step on a drive accumulator clamped to [0, pwm_limit].
// rsp channel: one transaction per request with the drive in Q.8 and the error.
// csr port: write-only registers prop_gain, deriv_time, sample_period, pwm_limit;
// write them only while no transaction is in flight.
// Sequence: after a request is accepted, the error division, the difference, the
// multiply states, the derivative division, the add states and the clamp run
// before rsp_tvalid rises. The error division is skipped when both samples are
// zero. The serial divider gives one quotient bit a cycle, run once for the error
// and once for the derivative term; a single shared multiplier forms each product.
// req_tready is high only while the controller is idle.
// Reset: registers return to their defaults, error history and accumulator clear.
// Stall: a finished result sits in the output register; the next request is taken
// meanwhile, and its result waits inside the controller until rsp_tready frees the
// register.
module differential_sensor_pd_controller
   import dspd_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // left_sample, right_sample
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // drive_out, steer_error
   output logic [RSP_TDATA_W-1:0]               rsp_tdata,
   input  logic                                 csr_wen,
   input  logic [CSR_IDX_W-1:0]                 csr_index,
   input  logic [CSR_W-1:0]                     csr_wdata
);

   cfg_type cfg_ff, cfg_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DRIVE_W-1:0]      rsp_drive_ff, rsp_drive_in;
   logic signed [ERR_W-1:0] rsp_error_ff, rsp_error_in;

   logic                    res_valid;
   logic                    res_ready;
   logic [DRIVE_W-1:0]      res_drive;
   logic signed [ERR_W-1:0] res_error;

   // Register writes, low bits kept
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index_type'(csr_index))
            REG_PROP_GAIN:     cfg_in.prop_gain     = csr_wdata[GAIN_W-1:0];
            REG_DERIV_TIME:    cfg_in.deriv_time    = csr_wdata[DTIME_W-1:0];
            REG_SAMPLE_PERIOD: cfg_in.sample_period = csr_wdata[PERIOD_W-1:0];
            REG_PWM_LIMIT:     cfg_in.pwm_limit     = csr_wdata[LIMIT_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain     <= PROP_GAIN_RST;
         cfg_ff.deriv_time    <= DERIV_TIME_RST;
         cfg_ff.sample_period <= SAMPLE_PERIOD_RST;
         cfg_ff.pwm_limit     <= PWM_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Output register: load when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_error_in = rsp_error_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_drive_in = res_drive;
            rsp_error_in = res_error;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_drive_ff <= rsp_drive_in;
      rsp_error_ff <= rsp_error_in;
   end

   dspd_ctrl #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .left_sample  (req_tdata[SAMPLE_BITS-1:0]),
      .right_sample (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res_drive    (res_drive),
      .res_error    (res_error)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-DRIVE_W-ERR_W){1'b0}}, rsp_error_ff, rsp_drive_ff};

endmodule
